>>> rtl/core/ipq_pkg.sv
// Shared types and constants of the indexed priority queue.
package ipq_pkg;

    localparam int FUNC_W = 3;
    localparam int ID_W   = 6;
    localparam int PRIO_W = 32;
    localparam int CNT_W  = 7;
    localparam int LIM_W  = 7;

    localparam logic [FUNC_W-1:0] FUNC_INSERT   = 3'd0;
    localparam logic [FUNC_W-1:0] FUNC_INCREASE = 3'd1;
    localparam logic [FUNC_W-1:0] FUNC_DECREASE = 3'd2;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE   = 3'd3;
    localparam logic [FUNC_W-1:0] FUNC_QUERY    = 3'd4;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 7'd64;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
    } t_ipq_cmd;

endpackage

>>> rtl/core/ipq_ctrl.sv
// Controller state machine of the indexed priority queue.
module ipq_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    output ipq_pkg::t_ipq_cmd o_cmd
);
    import ipq_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (start) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy       = (r_state == ST_EXEC);
    assign o_cmd.load = (r_state == ST_IDLE) && start;
    assign o_cmd.exec = (r_state == ST_EXEC);

endmodule

>>> rtl/core/ipq_dpath.sv
// Datapath of the indexed priority queue: sorted slot chain and result registers.
module ipq_dpath #(
    parameter int MAX_IDS    = 64,
    parameter int PRIO_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ipq_pkg::t_ipq_cmd           i_cmd,
    input  logic                        i_cfg_we,
    input  logic [ipq_pkg::LIM_W-1:0]   i_cfg_wdata,
    input  logic [ipq_pkg::FUNC_W-1:0]  i_func,
    input  logic [ipq_pkg::ID_W-1:0]    i_id,
    input  logic [ipq_pkg::PRIO_W-1:0]  i_priority_req,
    output logic                        o_done,
    output logic                        o_ok,
    output logic [ipq_pkg::ID_W-1:0]    o_out_id,
    output logic [ipq_pkg::PRIO_W-1:0]  o_out_priority,
    output logic [ipq_pkg::CNT_W-1:0]   o_count
);
    import ipq_pkg::*;

    localparam int IDX_W  = (MAX_IDS > 1) ? $clog2(MAX_IDS) : 1;
    localparam int QCNT_W = $clog2(MAX_IDS + 1);

    // Slot chain, slot 0 at the front.
    logic        [ID_W-1:0]       r_slot_id   [MAX_IDS];
    logic signed [PRIO_WIDTH-1:0] r_slot_prio [MAX_IDS];
    logic        [ID_W-1:0]       n_slot_id   [MAX_IDS];
    logic signed [PRIO_WIDTH-1:0] n_slot_prio [MAX_IDS];
    logic [MAX_IDS-1:0]           r_present;
    logic [MAX_IDS-1:0]           n_present;
    logic [QCNT_W-1:0]            r_count;
    logic [QCNT_W-1:0]            n_count;
    logic [LIM_W-1:0]             r_limit;

    logic [FUNC_W-1:0]            r_func;
    logic [ID_W-1:0]              r_id;
    logic signed [PRIO_WIDTH-1:0] r_key;

    logic                         r_done;
    logic                         r_ok;
    logic                         n_ok;
    logic [ID_W-1:0]              r_oid;
    logic [ID_W-1:0]              n_oid;
    logic [PRIO_WIDTH-1:0]        r_oprio;
    logic [PRIO_WIDTH-1:0]        n_oprio;

    logic [MAX_IDS-1:0]           valid_v;
    logic [MAX_IDS-1:0]           match_v;
    logic [MAX_IDS-1:0]           below_v;
    logic [MAX_IDS-1:0]           above_v;
    logic [MAX_IDS-1:0]           gt_v;
    logic [MAX_IDS-1:0]           lt_v;
    logic [MAX_IDS-1:0]           sh_v;
    logic [MAX_IDS-1:0]           gt2_v;
    logic [PRIO_WIDTH-1:0]        match_prio;
    logic                         id_ok;
    logic                         id_here;
    logic [IDX_W-1:0]             id_idx;
    logic [IDX_W-1:0]             front_idx;

    // Per-cell compares, all slots in parallel.
    always_comb begin
        match_prio = '0;
        for (int i = 0; i < MAX_IDS; i++) begin
            valid_v[i] = (QCNT_W'(i) < r_count);
            match_v[i] = valid_v[i] && (r_slot_id[i] == r_id);
            gt_v[i]    = valid_v[i] && (r_slot_prio[i] > r_key);
            lt_v[i]    = (r_slot_prio[i] < r_key);
            if (match_v[i]) begin
                match_prio = match_prio | r_slot_prio[i];
            end
        end
    end

    // One-hot match minus one marks the slots ahead of the matched entry.
    assign below_v = match_v - MAX_IDS'(1);
    assign above_v = ~(match_v | below_v);
    assign sh_v    = below_v & lt_v;
    assign gt2_v   = above_v & gt_v;

    assign id_idx    = IDX_W'(r_id);
    assign front_idx = IDX_W'(r_slot_id[0]);
    assign id_ok     = (32'(r_id) < 32'(r_limit)) && (32'(r_id) < MAX_IDS);
    assign id_here   = id_ok && r_present[id_idx];

    always_comb begin
        n_slot_id   = r_slot_id;
        n_slot_prio = r_slot_prio;
        n_present   = r_present;
        n_count     = r_count;
        n_ok        = 1'b0;
        n_oid       = '0;
        n_oprio     = '0;
        unique case (r_func)
            FUNC_INSERT: begin
                if (id_ok && !r_present[id_idx] && (32'(r_count) < MAX_IDS)) begin
                    for (int i = 0; i < MAX_IDS; i++) begin
                        if (!gt_v[i]) begin
                            if (i == 0 || gt_v[(i > 0) ? i - 1 : 0]) begin
                                n_slot_id[i]   = r_id;
                                n_slot_prio[i] = r_key;
                            end else begin
                                n_slot_id[i]   = r_slot_id[(i > 0) ? i - 1 : 0];
                                n_slot_prio[i] = r_slot_prio[(i > 0) ? i - 1 : 0];
                            end
                        end
                    end
                    n_present[id_idx] = 1'b1;
                    n_count           = r_count + QCNT_W'(1);
                    n_ok              = 1'b1;
                end
            end
            FUNC_INCREASE: begin
                if (id_here && (r_key > $signed(match_prio))) begin
                    for (int i = 0; i < MAX_IDS; i++) begin
                        if (match_v[i] || sh_v[i]) begin
                            if (i > 0 && sh_v[(i > 0) ? i - 1 : 0]) begin
                                n_slot_id[i]   = r_slot_id[(i > 0) ? i - 1 : 0];
                                n_slot_prio[i] = r_slot_prio[(i > 0) ? i - 1 : 0];
                            end else begin
                                n_slot_id[i]   = r_id;
                                n_slot_prio[i] = r_key;
                            end
                        end
                    end
                    n_ok = 1'b1;
                end
            end
            FUNC_DECREASE: begin
                if (id_here && (r_key < $signed(match_prio))) begin
                    for (int i = 0; i < MAX_IDS; i++) begin
                        if (match_v[i] || gt2_v[i]) begin
                            if (i + 1 < MAX_IDS && gt2_v[(i + 1 < MAX_IDS) ? i + 1 : i]) begin
                                n_slot_id[i]   = r_slot_id[(i + 1 < MAX_IDS) ? i + 1 : i];
                                n_slot_prio[i] = r_slot_prio[(i + 1 < MAX_IDS) ? i + 1 : i];
                            end else begin
                                n_slot_id[i]   = r_id;
                                n_slot_prio[i] = r_key;
                            end
                        end
                    end
                    n_ok = 1'b1;
                end
            end
            FUNC_REMOVE: begin
                if (r_count != '0) begin
                    n_oid   = r_slot_id[0];
                    n_oprio = r_slot_prio[0];
                    n_present[front_idx] = 1'b0;
                    for (int i = 0; i + 1 < MAX_IDS; i++) begin
                        n_slot_id[i]   = r_slot_id[i + 1];
                        n_slot_prio[i] = r_slot_prio[i + 1];
                    end
                    n_count = r_count - QCNT_W'(1);
                    n_ok    = 1'b1;
                end
            end
            FUNC_QUERY: begin
                if (id_here) begin
                    n_oprio = match_prio;
                    n_ok    = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present <= '0;
            r_count   <= '0;
            r_limit   <= LIMIT_RESET;
            r_done    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_done <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_present <= n_present;
                r_count   <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_id   <= i_id;
            r_key  <= PRIO_WIDTH'(64'(i_priority_req));
        end
        if (i_cmd.exec) begin
            r_slot_id   <= n_slot_id;
            r_slot_prio <= n_slot_prio;
            r_ok        <= n_ok;
            r_oid       <= n_oid;
            r_oprio     <= n_oprio;
        end
    end

    assign o_done         = r_done;
    assign o_ok           = r_ok;
    assign o_out_id       = r_oid;
    assign o_out_priority = PRIO_W'(64'(r_oprio));
    assign o_count        = CNT_W'(64'(r_count));

endmodule

>>> rtl/core/indexed_priority_queue_unit.sv
// Top level of the indexed priority queue with change-key.
//
//  Channel   Direction  Handshake                 Payload
//  command   in         start / busy              i_func, i_id, i_priority_req
//  result    out        o_done (one-cycle strobe) o_ok, o_out_id, o_out_priority, o_count
//  config    in         i_cfg_we                  i_cfg_wdata (id_limit)
//
// An item is taken at a clock edge where start is high and busy is low. The
// slot chain compares every stored priority against the new one in parallel,
// then shifts and writes all slots at once: busy is high for the single execute
// cycle, and the result strobe o_done comes in the cycle after it, while the
// next item may already be taken.
// Reset is synchronous and active low; it empties the queue and sets the id
// limit to 64. The result side cannot stall: each result is shown for exactly
// one cycle.
module indexed_priority_queue_unit #(
    parameter int MAX_IDS    = 64,
    parameter int PRIO_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [ipq_pkg::FUNC_W-1:0]  i_func,
    input  logic [ipq_pkg::ID_W-1:0]    i_id,
    input  logic [ipq_pkg::PRIO_W-1:0]  i_priority_req,
    input  logic                        i_cfg_we,
    input  logic [ipq_pkg::LIM_W-1:0]   i_cfg_wdata,
    output logic                        o_done,
    output logic                        o_ok,
    output logic [ipq_pkg::ID_W-1:0]    o_out_id,
    output logic [ipq_pkg::PRIO_W-1:0]  o_out_priority,
    output logic [ipq_pkg::CNT_W-1:0]   o_count
);
    import ipq_pkg::*;

    t_ipq_cmd cmd;

    // The controller sequences each item through its execute cycle.
    ipq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    // The datapath holds the sorted slot chain and the result registers.
    ipq_dpath #(
        .MAX_IDS    (MAX_IDS),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_func         (i_func),
        .i_id           (i_id),
        .i_priority_req (i_priority_req),
        .o_done         (o_done),
        .o_ok           (o_ok),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_count        (o_count)
    );

    // An accepted item always leads to the execute cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start execution");

    // Execution lasts a single cycle and is followed by exactly one result.
    a_exec_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (o_done && !busy))
        else $error("execute cycle not followed by its result");

    // A result only appears right after an execute cycle.
    a_result_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without an item");

    // The entry count never exceeds the queue depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(o_count) <= MAX_IDS)
        else $error("entry count beyond queue depth");

endmodule

>>> bench/tb.sv
// Self-checking testbench of the indexed priority queue unit.
`timescale 1ns / 100ps

import ipq_pkg::*;

// Tracks the queue contents and holds the results still owed by the block.
class ipq_scoreboard;
    typedef struct packed {
        logic              ok;
        logic [ID_W-1:0]   out_id;
        logic [PRIO_W-1:0] prio;
        logic [CNT_W-1:0]  count;
    } t_answer;

    logic [ID_W-1:0]          q_id[$];
    logic signed [PRIO_W-1:0] q_prio[$];
    bit                       present[64];
    int unsigned              limit;
    t_answer                  owed[$];
    int                       mismatches;
    int                       checked;
    int                       removes_ok;

    function new();
        limit = LIMIT_RESET;
        mismatches = 0;
        checked = 0;
        removes_ok = 0;
        for (int i = 0; i < 64; i++) present[i] = 0;
    endfunction

    function void set_limit(int unsigned v);
        limit = v;
    endfunction

    function int slot_of(logic [ID_W-1:0] id);
        for (int i = 0; i < q_id.size(); i++)
            if (q_id[i] == id) return i;
        return -1;
    endfunction

    // Apply one accepted item to the model queue and note its answer.
    function void note_item(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                            logic signed [PRIO_W-1:0] pr);
        t_answer a;
        int      p;
        bit      valid;
        a = '0;
        valid = (id < limit);
        case (f)
            FUNC_INSERT: begin
                if (valid && !present[id] && q_id.size() < 64) begin
                    p = 0;
                    while (p < q_id.size() && q_prio[p] > pr) p++;
                    q_id.insert(p, id);
                    q_prio.insert(p, pr);
                    present[id] = 1;
                    a.ok = 1;
                end
            end
            FUNC_INCREASE, FUNC_DECREASE: begin
                if (valid && present[id]) begin
                    p = slot_of(id);
                    if ((f == FUNC_INCREASE && pr > q_prio[p]) ||
                        (f == FUNC_DECREASE && pr < q_prio[p])) begin
                        q_id.delete(p);
                        q_prio.delete(p);
                        // Increase lands ahead of the first entry that is strictly
                        // lower; decrease lands after strictly higher ones.
                        p = 0;
                        if (f == FUNC_INCREASE)
                            while (p < q_id.size() && q_prio[p] >= pr) p++;
                        else
                            while (p < q_id.size() && q_prio[p] > pr) p++;
                        q_id.insert(p, id);
                        q_prio.insert(p, pr);
                        a.ok = 1;
                    end
                end
            end
            FUNC_REMOVE: begin
                if (q_id.size() > 0) begin
                    a.ok = 1;
                    a.out_id = q_id[0];
                    a.prio = q_prio[0];
                    present[q_id[0]] = 0;
                    void'(q_id.pop_front());
                    void'(q_prio.pop_front());
                    removes_ok++;
                end
            end
            FUNC_QUERY: begin
                if (valid && present[id]) begin
                    a.ok = 1;
                    a.prio = q_prio[slot_of(id)];
                end
            end
            default: ;
        endcase
        a.count = CNT_W'(q_id.size());
        owed.push_back(a);
    endfunction

    function void check_result(logic ok, logic [ID_W-1:0] oid,
                               logic [PRIO_W-1:0] op, logic [CNT_W-1:0] cnt);
        t_answer a;
        checked++;
        if (owed.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("result with nothing pending: ok=%0d id=%0d prio=%h count=%0d",
                         ok, oid, op, cnt);
            return;
        end
        a = owed.pop_front();
        if (a.ok !== ok || a.out_id !== oid || a.prio !== op || a.count !== cnt) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: expected ok=%0d id=%0d prio=%h count=%0d, got ok=%0d id=%0d prio=%h count=%0d",
                         a.ok, a.out_id, a.prio, a.count, ok, oid, op, cnt);
        end
    endfunction
endclass

module tb;
    localparam int WATCHDOG = 2000;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [FUNC_W-1:0] i_func;
    logic [ID_W-1:0]   i_id;
    logic [PRIO_W-1:0] i_priority_req;
    logic              i_cfg_we;
    logic [LIM_W-1:0]  i_cfg_wdata;
    logic              o_done;
    logic              o_ok;
    logic [ID_W-1:0]   o_out_id;
    logic [PRIO_W-1:0] o_out_priority;
    logic [CNT_W-1:0]  o_count;

    ipq_scoreboard queue_model;
    int            idle_pct;
    int            quiet_cycles;
    int            items_sent;

    indexed_priority_queue_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_func(i_func), .i_id(i_id), .i_priority_req(i_priority_req),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_done(o_done), .o_ok(o_ok), .o_out_id(o_out_id),
        .o_out_priority(o_out_priority), .o_count(o_count)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Results are sampled at the rising edge; the watchdog counts edges
    // at which neither an item nor a result moves.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            queue_model.check_result(o_ok, o_out_id, o_out_priority, o_count);
        if ((start && !busy) || o_done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    always @(posedge i_clk) begin
        if (quiet_cycles > WATCHDOG) begin
            $display("[indexed_priority_queue_unit] ERROR");
            $finish;
        end
    end

    // Drive one item, holding start until the block takes it. Random idle
    // gaps are inserted ahead of the item at the current idle rate. Start
    // stays high after the item is taken; the next idle gap or drain
    // lowers it before the block could take it again.
    task automatic send_item(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                             logic [PRIO_W-1:0] pr);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(negedge i_clk);
        end
        start <= 1;
        i_func <= f;
        i_id <= id;
        i_priority_req <= pr;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        queue_model.note_item(f, id, pr);
        items_sent++;
        @(negedge i_clk);
    endtask

    // Wait until every answer has arrived, then let the block settle.
    task automatic drain();
        start <= 0;
        while (queue_model.owed.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [LIM_W-1:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
        queue_model.set_limit(v);
    endtask

    // Random priorities: mostly from a small set so that ties are common,
    // sometimes full range or an extreme.
    function automatic logic [PRIO_W-1:0] rand_prio();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2, 3: return $urandom;
            default: return {16'($urandom_range(7)), 16'h0} - 32'h0003_0000;
        endcase
    endfunction

    // Weighted mix: inserts dominate so the queue fills and reorders.
    task automatic random_item(int unsigned id_span);
        int unsigned r;
        logic [FUNC_W-1:0] f;
        r = $urandom_range(99);
        if (r < 35)      f = FUNC_INSERT;
        else if (r < 50) f = FUNC_INCREASE;
        else if (r < 65) f = FUNC_DECREASE;
        else if (r < 82) f = FUNC_REMOVE;
        else if (r < 97) f = FUNC_QUERY;
        else             f = FUNC_W'($urandom_range(5, 7));
        send_item(f, ID_W'($urandom_range(id_span - 1)), rand_prio());
    endtask

    initial begin
        queue_model = new();
        quiet_cycles = 0;
        items_sent = 0;
        idle_pct = 0;
        i_rst_n = 0;
        start = 0;
        i_func = '0;
        i_id = '0;
        i_priority_req = '0;
        i_cfg_we = 0;
        i_cfg_wdata = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // Directed: empty remove, extremes, ties, duplicate, missing id,
        // non-strict changes, increase to the highest priority, unknown operation.
        send_item(FUNC_REMOVE, 0, 0);
        send_item(FUNC_QUERY, 5, 0);
        send_item(FUNC_INSERT, 63, 32'h7FFF_FFFF);
        send_item(FUNC_INSERT, 0, 32'h8000_0000);
        send_item(FUNC_INSERT, 10, 32'h0001_0000);
        send_item(FUNC_INSERT, 11, 32'h0001_0000);
        send_item(FUNC_INSERT, 10, 32'h0002_0000);
        send_item(FUNC_INCREASE, 11, 32'h0001_0000);
        send_item(FUNC_DECREASE, 11, 32'h0001_0000);
        send_item(FUNC_INCREASE, 0, 32'h7FFF_FFFF);
        send_item(FUNC_DECREASE, 63, 32'h8000_0000);
        send_item(FUNC_INCREASE, 20, 32'h0005_0000);
        send_item(FUNC_QUERY, 11, 0);
        send_item(3'd5, 10, 0);
        send_item(3'd7, 63, 32'hFFFF_FFFF);
        send_item(FUNC_QUERY, 63, 0);
        repeat (5) send_item(FUNC_REMOVE, 0, 0);

        // Id limit at its lowest settings, including zero.
        write_limit(0);
        send_item(FUNC_INSERT, 0, 32'h1234_5678);
        write_limit(1);
        send_item(FUNC_INSERT, 0, 32'h1234_5678);
        send_item(FUNC_INSERT, 1, 32'h1234_5678);
        send_item(FUNC_QUERY, 0, 0);

        // Random phases across idle rates and id limits.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: idle_pct = 0;
                1: idle_pct = 71;
                2: idle_pct = 0;
                default: idle_pct = 30;
            endcase
            case (ph)
                0: write_limit(64);
                2: write_limit(127);
                4: write_limit(7);
                6: write_limit(40);
                default: write_limit(64);
            endcase
            for (int k = 0; k < 35; k++)
                random_item(ph == 3 ? 8 : 64);
        end
        // Final phase fills the queue to capacity, then empties it.
        idle_pct = 0;
        for (int k = 0; k < 64; k++) send_item(FUNC_INSERT, k, rand_prio());
        send_item(FUNC_INSERT, 3, 0);
        for (int k = 0; k < 66; k++) send_item(FUNC_REMOVE, 0, 0);

        drain();
        $display("Covered %0d items, %0d results checked, %0d successful removes,",
                 items_sent, queue_model.checked, queue_model.removes_ok);
        $display("several id limits and sender idle rates, ties and full queue.");
        if (queue_model.mismatches == 0 && queue_model.owed.size() == 0) begin
            $display("[indexed_priority_queue_unit] OK");
        end else begin
            $display("[indexed_priority_queue_unit] ERROR");
        end
        $finish;
    end
endmodule

>>> sim.f
rtl/core/ipq_pkg.sv
rtl/core/ipq_ctrl.sv
rtl/core/ipq_dpath.sv
rtl/core/indexed_priority_queue_unit.sv
bench/tb.sv
